// ===== rtl/core/polygon_convexity_check_defines.svh =====
// Assertion macros for the checker file of polygon_convexity_check, pcc_checker.
// Each macro expects clk and rst_n in scope.
`ifndef POLYGON_CONVEXITY_CHECK_DEFINES_SVH
`define POLYGON_CONVEXITY_CHECK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcc: same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define PCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcc: next-cycle implication failed");

`endif

// ===== rtl/core/pcc_pkg.sv =====
// Types and constants for the polygon convexity checker.
// No dependencies; used by polygon_convexity_check and pcc_checker.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int FIELD_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;

    // Polygons with at most this many vertices are convex by definition.
    localparam int SMALL_POLY_MAX = 3;

    // Turn lanes: the running triple and the two closing triples.
    localparam int NUM_LANES     = 3;
    localparam int LANE_RUNNING  = 0;
    localparam int LANE_CLOSE_A  = 1;
    localparam int LANE_CLOSE_B  = 2;

    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] vertex_x;
        logic signed [FIELD_WIDTH-1:0] vertex_y;
        logic                          last_vertex;
    } pcc_vertex_t;

    typedef struct packed {
        logic                   is_convex;
        logic [TOTAL_WIDTH-1:0] vertex_total;
    } pcc_result_t;

endpackage

// ===== rtl/core/polygon_convexity_check.sv =====
// Streaming polygon convexity check by cross-product sign.
// Depends on pcc_pkg.
//
//  channel   handshake                     payload        moves
//  vertex    vertex_valid / vertex_ready   pcc_vertex_t   one vertex per transfer
//  result    result_valid / result_ready   pcc_result_t   one result per polygon
//
// One vertex per cycle sustained unless a stalled result backs up the pipe; the
// result passes edge differences, three-lane multiply, then sign and flags.
// The three-lane product stage sets the cycle: two multiplies per lane.
// rst_n clears all vertex state, the turn flags and every valid bit.
// A stalled result blocks only the next polygon's last vertex in the product
// stage; vertices keep flowing until that stage and the one ahead of it fill.
`timescale 1ns / 1ps

module polygon_convexity_check #(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vertex_valid,
    output logic                vertex_ready,
    input  pcc_pkg::pcc_vertex_t vertex,
    output logic                result_valid,
    input  logic                result_ready,
    output pcc_pkg::pcc_result_t result
);

    import pcc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // edge difference
    localparam int PW = 2 * DW;            // product
    localparam int CW = PW + 1;            // cross product
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Vertex state
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg, first_x_next, first_y_next;
    logic signed [COORD_WIDTH-1:0] second_x_reg, second_y_reg, second_x_next, second_y_next;
    logic signed [COORD_WIDTH-1:0] older_x_reg, older_y_reg, older_x_next, older_y_next;
    logic signed [COORD_WIDTH-1:0] newer_x_reg, newer_y_reg, newer_x_next, newer_y_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next, count_inc;

    // Stage 1: edge differences
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_last_reg;
    logic [COUNT_WIDTH-1:0] s1_count_reg;
    logic [NUM_LANES-1:0] s1_lane_reg, lane_next;
    logic signed [DW-1:0] s1_ux_reg[NUM_LANES], s1_uy_reg[NUM_LANES];
    logic signed [DW-1:0] s1_vx_reg[NUM_LANES], s1_vy_reg[NUM_LANES];
    logic signed [DW-1:0] ux_next[NUM_LANES], uy_next[NUM_LANES];
    logic signed [DW-1:0] vx_next[NUM_LANES], vy_next[NUM_LANES];

    // Stage 2: products
    logic                 s2_valid_reg, s2_valid_next;
    logic                 s2_last_reg;
    logic [COUNT_WIDTH-1:0] s2_count_reg;
    logic [NUM_LANES-1:0] s2_lane_reg;
    logic signed [PW-1:0] s2_p_reg[NUM_LANES], s2_q_reg[NUM_LANES];
    logic signed [PW-1:0] p_next[NUM_LANES], q_next[NUM_LANES];

    // Sticky turn flags and result register
    logic                 left_reg, left_next, right_reg, right_next;
    logic                 result_valid_reg, result_valid_next;
    pcc_result_t          result_reg;

    logic signed [COORD_WIDTH-1:0] vx, vy;
    logic signed [31:0]            vx_wide, vy_wide;
    logic signed [COORD_WIDTH-1:0] ax[NUM_LANES], ay[NUM_LANES];
    logic signed [COORD_WIDTH-1:0] bx[NUM_LANES], by[NUM_LANES];
    logic signed [COORD_WIDTH-1:0] cx[NUM_LANES], cy[NUM_LANES];
    logic signed [CW-1:0]          cross_prod[NUM_LANES];
    logic [NUM_LANES-1:0]          lane_left, lane_right;
    logic                          turn_left, turn_right;
    logic [31:0]                   count_ext;
    logic                          n_is0, n_is1;
    logic                          vertex_xfer, s1_move, s2_ready, s2_leave, out_free;
    logic                          emit;

    // Handshake
    always_comb
    begin
        out_free     = !result_valid_reg || result_ready;
        s2_ready     = !s2_valid_reg || !s2_last_reg || out_free;
        s2_leave     = s2_valid_reg && s2_ready;
        emit         = s2_leave && s2_last_reg;
        s1_move      = s1_valid_reg && s2_ready;
        vertex_ready = !s1_valid_reg || s2_ready;
        vertex_xfer  = vertex_valid && vertex_ready;
    end

    // Vertex intake: pick operands for the three triples, update state
    always_comb
    begin
        vx_wide = 32'(vertex.vertex_x);
        vy_wide = 32'(vertex.vertex_y);
        vx      = vx_wide[COORD_WIDTH-1:0];
        vy      = vy_wide[COORD_WIDTH-1:0];
        n_is0   = (count_reg == '0);
        n_is1   = (count_reg == COUNT_WIDTH'(1));
        count_inc = (count_reg != COUNT_MAX) ? count_reg + COUNT_WIDTH'(1) : count_reg;

        ax[LANE_RUNNING] = older_x_reg;  ay[LANE_RUNNING] = older_y_reg;
        bx[LANE_RUNNING] = newer_x_reg;  by[LANE_RUNNING] = newer_y_reg;
        cx[LANE_RUNNING] = vx;           cy[LANE_RUNNING] = vy;

        ax[LANE_CLOSE_A] = newer_x_reg;  ay[LANE_CLOSE_A] = newer_y_reg;
        bx[LANE_CLOSE_A] = vx;           by[LANE_CLOSE_A] = vy;
        cx[LANE_CLOSE_A] = first_x_reg;  cy[LANE_CLOSE_A] = first_y_reg;

        ax[LANE_CLOSE_B] = vx;           ay[LANE_CLOSE_B] = vy;
        bx[LANE_CLOSE_B] = first_x_reg;  by[LANE_CLOSE_B] = first_y_reg;
        // on a two-vertex polygon the second vertex is the current one
        cx[LANE_CLOSE_B] = n_is1 ? vx : second_x_reg;
        cy[LANE_CLOSE_B] = n_is1 ? vy : second_y_reg;

        lane_next[LANE_RUNNING] = !n_is0 && !n_is1;
        lane_next[LANE_CLOSE_A] = vertex.last_vertex && !n_is0;
        lane_next[LANE_CLOSE_B] = vertex.last_vertex && !n_is0;

        for (int i = 0; i < NUM_LANES; i++)
        begin
            ux_next[i] = DW'(bx[i]) - DW'(ax[i]);
            uy_next[i] = DW'(by[i]) - DW'(ay[i]);
            vx_next[i] = DW'(cx[i]) - DW'(ax[i]);
            vy_next[i] = DW'(cy[i]) - DW'(ay[i]);
        end

        first_x_next  = first_x_reg;   first_y_next  = first_y_reg;
        second_x_next = second_x_reg;  second_y_next = second_y_reg;
        older_x_next  = older_x_reg;   older_y_next  = older_y_reg;
        newer_x_next  = newer_x_reg;   newer_y_next  = newer_y_reg;
        count_next    = count_reg;
        if (vertex_xfer)
        begin
            if (vertex.last_vertex)
            begin
                // start the next polygon from the reset state
                first_x_next  = '0;  first_y_next  = '0;
                second_x_next = '0;  second_y_next = '0;
                older_x_next  = '0;  older_y_next  = '0;
                newer_x_next  = '0;  newer_y_next  = '0;
                count_next    = '0;
            end
            else
            begin
                if (n_is0)
                begin
                    first_x_next = vx;
                    first_y_next = vy;
                end
                if (n_is1)
                begin
                    second_x_next = vx;
                    second_y_next = vy;
                end
                older_x_next = newer_x_reg;  older_y_next = newer_y_reg;
                newer_x_next = vx;           newer_y_next = vy;
                count_next   = count_inc;
            end
        end
    end

    // Products
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            p_next[i] = PW'(s1_ux_reg[i]) * PW'(s1_vy_reg[i]);
            q_next[i] = PW'(s1_uy_reg[i]) * PW'(s1_vx_reg[i]);
        end
    end

    // Cross-product sign and turn flags
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            cross_prod[i] = CW'(s2_p_reg[i]) - CW'(s2_q_reg[i]);
            lane_right[i] = s2_lane_reg[i] && cross_prod[i][CW-1];
            lane_left[i]  = s2_lane_reg[i] && !cross_prod[i][CW-1] && (cross_prod[i] != '0);
        end
        turn_left  = left_reg  || (|lane_left);
        turn_right = right_reg || (|lane_right);
        count_ext  = 32'(s2_count_reg);

        left_next  = left_reg;
        right_next = right_reg;
        if (s2_leave)
        begin
            left_next  = s2_last_reg ? 1'b0 : turn_left;
            right_next = s2_last_reg ? 1'b0 : turn_right;
        end

        result_valid_next = result_valid_reg;
        if (emit)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;

        s1_valid_next = s1_valid_reg;
        if (vertex_xfer)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_move)
            s2_valid_next = 1'b1;
        else if (s2_leave)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            second_x_reg     <= '0;
            second_y_reg     <= '0;
            older_x_reg      <= '0;
            older_y_reg      <= '0;
            newer_x_reg      <= '0;
            newer_y_reg      <= '0;
            count_reg        <= '0;
            left_reg         <= 1'b0;
            right_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            first_x_reg      <= first_x_next;
            first_y_reg      <= first_y_next;
            second_x_reg     <= second_x_next;
            second_y_reg     <= second_y_next;
            older_x_reg      <= older_x_next;
            older_y_reg      <= older_y_next;
            newer_x_reg      <= newer_x_next;
            newer_y_reg      <= newer_y_next;
            count_reg        <= count_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (vertex_xfer)
        begin
            s1_last_reg  <= vertex.last_vertex;
            s1_count_reg <= count_inc;
            s1_lane_reg  <= lane_next;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                s1_ux_reg[i] <= ux_next[i];
                s1_uy_reg[i] <= uy_next[i];
                s1_vx_reg[i] <= vx_next[i];
                s1_vy_reg[i] <= vy_next[i];
            end
        end
        if (s1_move)
        begin
            s2_last_reg  <= s1_last_reg;
            s2_count_reg <= s1_count_reg;
            s2_lane_reg  <= s1_lane_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                s2_p_reg[i] <= p_next[i];
                s2_q_reg[i] <= q_next[i];
            end
        end
        if (emit)
        begin
            result_reg.is_convex    <= (count_ext <= 32'(SMALL_POLY_MAX))
                                       || !(turn_left && turn_right);
            result_reg.vertex_total <= (count_ext > 32'(TOTAL_MAX))
                                       ? TOTAL_MAX : count_ext[TOTAL_WIDTH-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/pcc_checker.sv =====
// Port-level checks for polygon_convexity_check, attached by bind.
// Depends on pcc_pkg and polygon_convexity_check_defines.svh.
`timescale 1ns / 1ps
`include "polygon_convexity_check_defines.svh"

module pcc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 vertex_valid,
    input logic                 vertex_ready,
    input pcc_pkg::pcc_vertex_t vertex,
    input logic                 result_valid,
    input logic                 result_ready,
    input pcc_pkg::pcc_result_t result
);

    import pcc_pkg::*;

    // Hold a stalled result
    `PCC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // A mixed-turn verdict needs more than a triangle
    `PCC_ASSERT_IMPLY(a_concave_size, result_valid && !result.is_convex, result.vertex_total > 16'(SMALL_POLY_MAX))

    // Every polygon holds at least its last vertex
    `PCC_ASSERT_IMPLY(a_total_nonzero, result_valid, result.vertex_total != '0)

endmodule

bind polygon_convexity_check pcc_checker u_pcc_checker (.*);
